// File: design/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared widths, operation codes and register indexes for the dense matrix
// multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

    localparam int OP_W      = 2;
    localparam int POS_W     = 3;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int VALUE_W   = 35;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_WRITE_A = 2'd0;
    localparam op_t OP_WRITE_B = 2'd1;
    localparam op_t OP_RUN     = 2'd2;

    localparam cfg_idx_t REG_ROWS_M  = 2'd0;
    localparam cfg_idx_t REG_COLS_N  = 2'd1;
    localparam cfg_idx_t REG_INNER_K = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

endpackage

// File: design/dense_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top
// C = A * B on signed Q8.8 elements with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each transaction is either a load of one element of
//   A or B at (s_row, s_col), or a run. A load with an index not below
//   MAX_DIM is dropped. Op code 3 is dropped too.
//   A run walks C in row-major order and presents each element on the result
//   channel (m_*), with m_last on the final one. s_ready is low from the run
//   until the last result has been taken.
//   Each result element is formed on the single MAC with one read of both
//   stores per product; the registered read and product stages then drain
//   and the sum settles before the element is shown. A stalled receiver
//   simply holds the sequencer on the current element.
//   Dimensions are sampled at the start of a run; values above MAX_DIM count
//   as MAX_DIM, and a zero row or column count gives a run with no results.
//   Reset sets all three dimensions to 8 and empties the pipeline; the
//   element stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_top
    import dmm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic [POS_W-1:0]          s_row,
    input  logic [POS_W-1:0]          s_col,
    input  logic signed [ELEM_W-1:0]  s_elem_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [POS_W-1:0]          m_out_row,
    output logic [POS_W-1:0]          m_out_col,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic                      m_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam logic [CFG_W-1:0] MAX_DIM_CFG = CFG_W'(MAX_DIM);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    function automatic logic [CNT_W-1:0] dim_clamp(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        c = (v > MAX_DIM_CFG) ? MAX_DIM_CFG : v;
        return CNT_W'(c);
    endfunction

    logic [CFG_W-1:0] rows_m_reg, cols_n_reg, inner_k_reg;
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] m_reg, m_next, n_reg, n_next, k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, p_reg, p_next;
    logic             rd_vld_reg, rd_vld_next, prod_vld_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;

    logic              s_fire, m_fire, in_range, issue, last_elem, row_end;
    logic              a_we, b_we;
    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign in_range = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
    assign wr_addr  = ADDR_W'(32'(s_row) * MAX_DIM + 32'(s_col));
    assign a_we     = s_fire && (s_op == OP_WRITE_A) && in_range;
    assign b_we     = s_fire && (s_op == OP_WRITE_B) && in_range;

    assign issue   = (state_reg == ST_CALC) && (p_reg != k_reg);
    assign a_raddr = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(p_reg));
    assign b_raddr = ADDR_W'(32'(p_reg) * MAX_DIM + 32'(j_reg));

    assign row_end   = (CNT_W'(j_reg + 1'b1) == n_reg);
    assign last_elem = row_end && (CNT_W'(i_reg + 1'b1) == m_reg);

    dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (wr_addr),
        .wr_data (s_elem_value),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (wr_addr),
        .wr_data (s_elem_value),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    // Dimension registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= DIM_RESET;
            cols_n_reg  <= DIM_RESET;
            inner_k_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ROWS_M:  rows_m_reg  <= cfg_wr_data;
                REG_COLS_N:  cols_n_reg  <= cfg_wr_data;
                REG_INNER_K: inner_k_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        acc_next    = acc_reg;
        rd_vld_next = issue;
        if (prod_vld_reg) begin
            acc_next = acc_reg + VALUE_W'(prod_reg);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_RUN)) begin
                    m_next   = dim_clamp(rows_m_reg);
                    n_next   = dim_clamp(cols_n_reg);
                    k_next   = dim_clamp(inner_k_reg);
                    i_next   = '0;
                    j_next   = '0;
                    p_next   = '0;
                    acc_next = '0;
                    if ((rows_m_reg != '0) && (cols_n_reg != '0)) begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                if (issue) begin
                    p_next = CNT_W'(p_reg + 1'b1);
                end else if (!rd_vld_reg && !prod_vld_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    p_next   = '0;
                    acc_next = '0;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CALC;
                        if (row_end) begin
                            j_next = '0;
                            i_next = CNT_W'(i_reg + 1'b1);
                        end else begin
                            j_next = CNT_W'(j_reg + 1'b1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        prod_reg <= $signed(a_rdata) * $signed(b_rdata);
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign m_out_row   = POS_W'(i_reg);
    assign m_out_col   = POS_W'(j_reg);
    assign m_out_value = acc_reg;
    assign m_last      = last_elem;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!rd_vld_reg && !prod_vld_reg && (p_reg == k_reg)))
        else $error("result shown before the MAC pipeline drained");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("sequencer did not return to idle after last result");

    a_mid_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (!s_ready && !m_valid))
        else $error("sequencer skipped the next element");
`endif

endmodule

// File: design/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: bench/tb_dense_matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_matrix_multiply_top
// Self-checking bench for the dense matrix multiply block. A queue-fed driver
// loads elements of A and B and issues runs; a monitor checks every element
// of C against a behavioural GEMM predictor. The bench steps through several
// dimension settings, including zero, clamped and full sizes, under random
// source and sink stalls.
// ----------------------------------------------------------------------------
module tb_dense_matrix_multiply_top;
    import dmm_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int LOAD_TARGET   = 380;

    localparam op_t      OP_UNUSED  = 2'd3;
    localparam cfg_idx_t REG_UNUSED = 2'd3;

    typedef struct {
        op_t                op;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [ELEM_W-1:0]  value;
    } mm_txn_t;

    typedef struct {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } c_elem_t;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_addr     = '0;
    logic [CFG_W-1:0]          cfg_wr_data  = '0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op         = '0;
    logic [POS_W-1:0]          s_row        = '0;
    logic [POS_W-1:0]          s_col        = '0;
    logic signed [ELEM_W-1:0]  s_elem_value = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic [POS_W-1:0]          m_out_row;
    logic [POS_W-1:0]          m_out_col;
    logic signed [VALUE_W-1:0] m_out_value;
    logic                      m_last;

    dense_matrix_multiply_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_elem_value(s_elem_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_value (m_out_value),
        .m_last      (m_last)
    );

    always #5 aclk = ~aclk;

    // Predictor state: element stores and dimension registers
    logic signed [ELEM_W-1:0] a_elems [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_elems [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]         dim_rows  = DIM_RESET;
    logic [CFG_W-1:0]         dim_cols  = DIM_RESET;
    logic [CFG_W-1:0]         dim_inner = DIM_RESET;

    // Stimulus-side record of which store entries hold a known value
    bit a_loaded [MAX_DIM*MAX_DIM];
    bit b_loaded [MAX_DIM*MAX_DIM];

    mm_txn_t pending_txns [$];
    c_elem_t c_elems_due  [$];
    mm_txn_t next_txn;
    c_elem_t due_elem;

    int src_idle_pct    = 0;
    int sink_idle_pct   = 0;
    int txns_queued     = 0;
    int txns_accepted   = 0;
    int loads_counted   = 0;
    int runs_sent       = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int settings_used   = 0;

    logic [CFG_W-1:0] fixed_m [6] = '{4'd0, 4'd3, 4'd3, 4'd15, 4'd9, 4'd1};
    logic [CFG_W-1:0] fixed_n [6] = '{4'd3, 4'd0, 4'd3, 4'd15, 4'd1, 4'd8};
    logic [CFG_W-1:0] fixed_k [6] = '{4'd3, 4'd3, 4'd0, 4'd15, 4'd12, 4'd1};

    function automatic int eff_dim(input logic [CFG_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // Highest index for a write aimed at the active area; whole range if empty
    function automatic int span(input int d);
        return (d == 0) ? MAX_DIM - 1 : d - 1;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        if ($urandom_range(99) < 85)
            return CFG_W'($urandom_range(1, 4));
        return CFG_W'($urandom_range(5, MAX_DIM));
    endfunction

    // GEMM predictor, applied to each accepted transaction
    task automatic predict_gemm(input op_t op, input logic [POS_W-1:0] r,
                                input logic [POS_W-1:0] c,
                                input logic signed [ELEM_W-1:0] v);
        int      m, n, k;
        longint  acc;
        c_elem_t e;
        case (op)
            OP_WRITE_A: a_elems[{r, c}] = v;
            OP_WRITE_B: b_elems[{r, c}] = v;
            OP_RUN: begin
                m = eff_dim(dim_rows);
                n = eff_dim(dim_cols);
                k = eff_dim(dim_inner);
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = 0;
                        for (int p = 0; p < k; p++)
                            acc += longint'(a_elems[i*MAX_DIM+p]) *
                                   longint'(b_elems[p*MAX_DIM+j]);
                        e.row   = POS_W'(i);
                        e.col   = POS_W'(j);
                        e.value = acc[VALUE_W-1:0];
                        e.last  = (i == m - 1) && (j == n - 1);
                        c_elems_due.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_txn(input op_t op, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input logic [ELEM_W-1:0] v);
        mm_txn_t t;
        t.op    = op;
        t.row   = r;
        t.col   = c;
        t.value = v;
        pending_txns.push_back(t);
        txns_queued++;
        if (op == OP_WRITE_A) a_loaded[{r, c}] = 1'b1;
        if (op == OP_WRITE_B) b_loaded[{r, c}] = 1'b1;
        if (op != OP_UNUSED) loads_counted++;
        if (op == OP_RUN) runs_sent++;
    endtask

    // Fill any entry the run will read that has never been loaded, then run
    task automatic queue_run();
        int m, n, k;
        m = eff_dim(dim_rows);
        n = eff_dim(dim_cols);
        k = eff_dim(dim_inner);
        for (int i = 0; i < m; i++)
            for (int p = 0; p < k; p++)
                if (!a_loaded[i*MAX_DIM+p])
                    queue_txn(OP_WRITE_A, POS_W'(i), POS_W'(p), pick_elem());
        for (int p = 0; p < k; p++)
            for (int j = 0; j < n; j++)
                if (!b_loaded[p*MAX_DIM+j])
                    queue_txn(OP_WRITE_B, POS_W'(p), POS_W'(j), pick_elem());
        queue_txn(OP_RUN, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom));
    endtask

    task automatic wait_drained();
        while (txns_accepted != txns_queued || c_elems_due.size() != 0)
            @(posedge aclk);
        // a run with no results never leaves the idle state; this wait is extra margin
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_ROWS_M:  dim_rows  = val;
            REG_COLS_N:  dim_cols  = val;
            REG_INNER_K: dim_inner = val;
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                               input logic [CFG_W-1:0] k, input bit poke_unused);
        wait_drained();
        write_reg(REG_ROWS_M, m);
        write_reg(REG_COLS_N, n);
        write_reg(REG_INNER_K, k);
        if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
        if (loads_counted < 130) begin
            src_idle_pct  = 36;
            sink_idle_pct = 57;
        end else if (loads_counted < 255) begin
            src_idle_pct  = 57;
            sink_idle_pct = 36;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
    endtask

    // Source driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_gemm(s_op, s_row, s_col, s_elem_value);
                txns_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_txns.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_txn = pending_txns.pop_front();
                    s_valid      <= 1'b1;
                    s_op         <= next_txn.op;
                    s_row        <= next_txn.row;
                    s_col        <= next_txn.col;
                    s_elem_value <= next_txn.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (c_elems_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected C element row %0d col %0d value %0d",
                                 $realtime, m_out_row, m_out_col, m_out_value);
                end else begin
                    due_elem = c_elems_due.pop_front();
                    results_checked++;
                    if (m_out_row !== due_elem.row || m_out_col !== due_elem.col ||
                        m_out_value !== $signed(due_elem.value) ||
                        m_last !== due_elem.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: C mismatch exp (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
                                     $realtime, due_elem.row, due_elem.col,
                                     $signed(due_elem.value), due_elem.last,
                                     m_out_row, m_out_col, m_out_value, m_last);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        int seg_goal;
        int roll;
        int m, n, k;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme elements on a 2x2x2 product, unused op between runs
        reconfigure(4'd2, 4'd2, 4'd2, 1'b0);
        queue_txn(OP_WRITE_A, 3'd0, 3'd0, 16'h7FFF);
        queue_txn(OP_WRITE_A, 3'd0, 3'd1, 16'h8000);
        queue_txn(OP_WRITE_A, 3'd1, 3'd0, 16'h8000);
        queue_txn(OP_WRITE_A, 3'd1, 3'd1, 16'h0001);
        queue_txn(OP_WRITE_B, 3'd0, 3'd0, 16'h8000);
        queue_txn(OP_WRITE_B, 3'd0, 3'd1, 16'h7FFF);
        queue_txn(OP_WRITE_B, 3'd1, 3'd0, 16'h8000);
        queue_txn(OP_WRITE_B, 3'd1, 3'd1, 16'hFFFF);
        queue_run();
        queue_txn(OP_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        queue_run();

        // Directed: largest possible dot product, eight times (-128)*(-128)
        reconfigure(4'd1, 4'd1, 4'd8, 1'b0);
        for (int p = 0; p < MAX_DIM; p++) begin
            queue_txn(OP_WRITE_A, 3'd0, POS_W'(p), 16'h8000);
            queue_txn(OP_WRITE_B, POS_W'(p), 3'd0, 16'h8000);
        end
        queue_run();

        // Fixed corner settings first (zero sizes, clamping), then random ones
        for (int seg = 0; loads_counted < LOAD_TARGET; seg++) begin
            if (seg < 6)
                reconfigure(fixed_m[seg], fixed_n[seg], fixed_k[seg], seg == 3);
            else
                reconfigure(pick_dim(), pick_dim(), pick_dim(), 1'b0);
            m = eff_dim(dim_rows);
            n = eff_dim(dim_cols);
            k = eff_dim(dim_inner);
            seg_goal = loads_counted + 24;
            while (loads_counted < seg_goal) begin
                roll = $urandom_range(99);
                if (roll < 65) begin
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(1))
                            queue_txn(OP_WRITE_A, POS_W'($urandom_range(span(m))),
                                      POS_W'($urandom_range(span(k))), pick_elem());
                        else
                            queue_txn(OP_WRITE_B, POS_W'($urandom_range(span(k))),
                                      POS_W'($urandom_range(span(n))), pick_elem());
                    end
                    queue_run();
                end else if (roll < 85) begin
                    // loads anywhere in the stores, no run to follow
                    repeat ($urandom_range(1, 3))
                        queue_txn($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B,
                                  POS_W'($urandom), POS_W'($urandom), pick_elem());
                end else begin
                    queue_txn(OP_UNUSED, POS_W'($urandom), POS_W'($urandom),
                              ELEM_W'($urandom));
                end
            end
        end

        wait_drained();
        $display("Sent %0d loads and runs (%0d runs) over %0d dimension settings",
                 loads_counted, runs_sent, settings_used);
        $display("Checked %0d C elements, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && c_elems_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d C elements outstanding", c_elems_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
